// File: hw/rtl/dsh_pkg.sv
package dsh_pkg;

    // grid geometry
    localparam int GRID_POWER = 8;
    localparam int LEN        = 1 << GRID_POWER;
    localparam int SIDE       = LEN + 1;
    localparam int CELLS      = SIDE * SIDE;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = GRID_POWER + 1;

    // arithmetic widths
    localparam int HW   = 18;
    localparam int SUMW = HW + 2;
    localparam int PW   = 15 + CW;
    localparam int TW   = CW + 9;
    localparam int VW   = ((TW > HW + 1) ? TW : HW + 1) + 1;
    localparam int D3W  = 2 * SUMW;

    // generator
    localparam logic [31:0] LCG_MUL = 32'h0003_43FD;
    localparam logic [31:0] LCG_INC = 32'h0026_9EC3;

    // floor divide by three through a biased reciprocal
    localparam logic [SUMW-1:0] DIV3_BIAS  = SUMW'(3 * 131072);
    localparam logic [SUMW-1:0] DIV3_RECIP = SUMW'(699051);
    localparam int              DIV3_SHIFT = 21;
    localparam int              DIV3_OFF   = 131072;

    localparam int HMIN = -131072;
    localparam int HMAX = 131071;

    // request codes
    localparam logic [1:0] OP_RESET  = 2'd0;
    localparam logic [1:0] OP_ITER   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef struct packed {
        logic [AW-1:0] rd_addr;
        logic          acc;
        logic          sum_clr;
        logic          rand_step;
        logic          seed_load;
        logic          wr_en;
        logic          wr_zero;
        logic [AW-1:0] wr_addr;
        logic [CW-1:0] scale;
        logic          out_load;
        logic          out_hit;
        logic          out_done;
    } dsh_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dsh_status_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        logic [AW-1:0] xa;
        logic [AW-1:0] ya;
        xa = AW'(x);
        ya = AW'(y);
        return (xa << GRID_POWER) + xa + ya;
    endfunction

endpackage

// File: hw/rtl/dsh_datapath.sv
module dsh_datapath import dsh_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  dsh_cmd_t           cmd,
    input  logic [31:0]        s_seed,
    input  logic               m_ready,
    output dsh_status_t        status,
    output logic               m_valid,
    output logic signed [17:0] m_height,
    output logic               m_done_res
);

    logic signed [HW-1:0]   grid_mem [CELLS];
    logic signed [HW-1:0]   rd_data_reg;
    logic [31:0]            lcg_reg, lcg_next;
    logic                   acc_pend_reg, acc_pend_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic [2:0]             cnt_reg, cnt_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [D3W-1:0]         div3_reg, div3_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [HW-1:0]   m_height_reg, m_height_next;
    logic                   m_done_reg, m_done_next;

    logic [14:0]            rnd;
    logic [SUMW-1:0]        biased;
    logic signed [VW-1:0]   term, avg_v, val;
    logic signed [HW-1:0]   wdata;

    // memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            grid_mem[cmd.wr_addr] <= wdata;
        end
        rd_data_reg <= grid_mem[cmd.rd_addr];
    end

    always_comb begin
        rnd       = lcg_reg[30:16];
        lcg_next  = cmd.seed_load ? s_seed :
                    (cmd.rand_step ? lcg_reg * LCG_MUL + LCG_INC : lcg_reg);
        prod_next = PW'(rnd) * PW'(cmd.scale);

        acc_pend_next = cmd.acc;
        if (cmd.sum_clr) begin
            sum_next = '0;
            cnt_next = '0;
        end else if (acc_pend_reg) begin
            sum_next = sum_reg + SUMW'(rd_data_reg);
            cnt_next = cnt_reg + 3'd1;
        end else begin
            sum_next = sum_reg;
            cnt_next = cnt_reg;
        end

        biased    = $unsigned(sum_reg) + DIV3_BIAS;
        div3_next = D3W'(biased) * D3W'(DIV3_RECIP);

        term = $signed(VW'(prod_reg >> 7) - (VW'(cmd.scale) << 7));
        if (cnt_reg == 3'd3) begin
            avg_v = $signed(VW'(div3_reg >> DIV3_SHIFT)) - VW'(DIV3_OFF);
        end else begin
            avg_v = VW'(sum_reg >>> 2);
        end
        val = avg_v + term;
        if (val < VW'(HMIN)) begin
            wdata = HW'(HMIN);
        end else if (val > VW'(HMAX)) begin
            wdata = HW'(HMAX);
        end else begin
            wdata = val[HW-1:0];
        end
        if (cmd.wr_zero) begin
            wdata = '0;
        end

        m_valid_next  = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_height_next = cmd.out_load ? (cmd.out_hit ? rd_data_reg : '0) : m_height_reg;
        m_done_next   = cmd.out_load ? cmd.out_done : m_done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg      <= '0;
            acc_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            lcg_reg      <= lcg_next;
            acc_pend_reg <= acc_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        div3_reg     <= div3_next;
        m_height_reg <= m_height_next;
        m_done_reg   <= m_done_next;
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;
    assign m_height        = m_height_reg;
    assign m_done_res      = m_done_reg;

endmodule

// File: hw/rtl/dsh_ctrl.sv
module dsh_ctrl import dsh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [8:0]  s_row,
    input  logic [8:0]  s_column,
    input  dsh_status_t status,
    output dsh_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PT    = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_AVG   = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_RDH   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [CW-1:0] LEN_C  = CW'(LEN);
    localparam logic [CW:0]   LEN_E  = (CW + 1)'(LEN);

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          pend_reg, pend_next;
    logic          corner_reg, corner_next;
    logic [1:0]    ci_reg, ci_next;
    logic [1:0]    k_reg, k_next;
    logic [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [CW-1:0] stride_reg, stride_next;
    logic          diamond_reg, diamond_next;
    logic          odd_reg, odd_next;
    logic          finish_reg, finish_next;
    logic          hit_reg, hit_next;
    logic [CW-1:0] rx_reg, rx_next, ry_reg, ry_next;

    logic [CW-1:0] half;
    logic [CW:0]   xe, ye, he, se, nx, ny, y_step, x_sstep, x_hstep;
    logic          nvalid, hit_in;
    logic [CW-1:0] px, py;

    always_comb begin
        half = stride_reg >> 1;
        xe   = {1'b0, x_reg};
        ye   = {1'b0, y_reg};
        he   = {1'b0, half};
        se   = {1'b0, stride_reg};

        nx     = xe;
        ny     = ye;
        nvalid = 1'b0;
        if (!corner_reg && !diamond_reg) begin
            nx     = k_reg[1] ? xe + he : xe - he;
            ny     = k_reg[0] ? ye + he : ye - he;
            nvalid = 1'b1;
        end else if (!corner_reg) begin
            unique case (k_reg)
                2'd0: begin
                    ny     = ye - he;
                    nvalid = ye >= he;
                end
                2'd1: begin
                    ny     = ye + he;
                    nvalid = (ye + he) <= LEN_E;
                end
                2'd2: begin
                    nx     = xe - he;
                    nvalid = xe >= he;
                end
                default: begin
                    nx     = xe + he;
                    nvalid = (xe + he) <= LEN_E;
                end
            endcase
        end

        px = corner_reg ? (ci_reg[1] ? LEN_C : '0) : x_reg;
        py = corner_reg ? (ci_reg[0] ? LEN_C : '0) : y_reg;

        y_step  = ye + se;
        x_sstep = xe + se;
        x_hstep = xe + he;
        hit_in  = (int'(s_row) < SIDE) && (int'(s_column) < SIDE);
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        pend_next    = pend_reg;
        corner_next  = corner_reg;
        ci_next      = ci_reg;
        k_next       = k_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        stride_next  = stride_reg;
        diamond_next = diamond_reg;
        odd_next     = odd_reg;
        finish_next  = finish_reg;
        hit_next     = hit_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;

        s_ready       = 1'b0;
        cmd.rd_addr   = cell_addr(rx_reg, ry_reg);
        cmd.acc       = 1'b0;
        cmd.sum_clr   = 1'b0;
        cmd.rand_step = 1'b0;
        cmd.seed_load = 1'b0;
        cmd.wr_en     = 1'b0;
        cmd.wr_zero   = 1'b0;
        cmd.wr_addr   = cell_addr(px, py);
        cmd.scale     = corner_reg ? stride_reg : half;
        cmd.out_load  = 1'b0;
        cmd.out_hit   = hit_reg;
        cmd.out_done  = stride_reg == CW'(1);

        unique case (state_reg)
            S_CLEAR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_zero = 1'b1;
                cmd.wr_addr = clr_reg;
                clr_next    = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1)) begin
                    clr_next = '0;
                    if (pend_reg) begin
                        pend_next   = 1'b0;
                        corner_next = 1'b1;
                        ci_next     = '0;
                        k_next      = '0;
                        state_next  = S_PT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    hit_next = 1'b0;
                    unique case (s_op)
                        OP_RESET: begin
                            cmd.seed_load = 1'b1;
                            stride_next   = LEN_C;
                            pend_next     = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_ITER, OP_FINISH: begin
                            finish_next = s_op == OP_FINISH;
                            if (stride_reg <= CW'(1)) begin
                                state_next = S_OUT;
                            end else begin
                                corner_next  = 1'b0;
                                diamond_next = 1'b0;
                                x_next       = half;
                                y_next       = half;
                                k_next       = '0;
                                state_next   = S_PT;
                            end
                        end
                        default: begin
                            hit_next   = hit_in;
                            rx_next    = hit_in ? CW'(s_row) : '0;
                            ry_next    = hit_in ? CW'(s_column) : '0;
                            state_next = S_RDH;
                        end
                    endcase
                end
            end
            S_PT: begin
                cmd.rd_addr   = cell_addr(nx[CW-1:0], ny[CW-1:0]);
                cmd.acc       = nvalid;
                cmd.sum_clr   = k_reg == 2'd0;
                cmd.rand_step = k_reg == 2'd0;
                k_next        = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                state_next = S_AVG;
            end
            S_AVG: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.wr_en  = 1'b1;
                k_next     = '0;
                state_next = S_PT;
                if (corner_reg) begin
                    ci_next = ci_reg + 2'd1;
                    if (ci_reg == 2'd3) begin
                        corner_next = 1'b0;
                        state_next  = S_OUT;
                    end
                end else if (!diamond_reg) begin
                    if (y_step < LEN_E) begin
                        y_next = y_step[CW-1:0];
                    end else if (x_sstep < LEN_E) begin
                        x_next = x_sstep[CW-1:0];
                        y_next = half;
                    end else begin
                        diamond_next = 1'b1;
                        odd_next     = 1'b0;
                        x_next       = '0;
                        y_next       = half;
                    end
                end else begin
                    if (y_step <= LEN_E) begin
                        y_next = y_step[CW-1:0];
                    end else if (x_hstep <= LEN_E) begin
                        x_next   = x_hstep[CW-1:0];
                        odd_next = !odd_reg;
                        y_next   = odd_reg ? half : '0;
                    end else begin
                        stride_next = half;
                        if (finish_reg && half > CW'(1)) begin
                            diamond_next = 1'b0;
                            x_next       = half >> 1;
                            y_next       = half >> 1;
                        end else begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_RDH: begin
                state_next = S_OUT;
            end
            default: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            corner_reg  <= 1'b0;
            ci_reg      <= '0;
            k_reg       <= '0;
            stride_reg  <= LEN_C;
            diamond_reg <= 1'b0;
            odd_reg     <= 1'b0;
            finish_reg  <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            corner_reg  <= corner_next;
            ci_reg      <= ci_next;
            k_reg       <= k_next;
            stride_reg  <= stride_next;
            diamond_reg <= diamond_next;
            odd_reg     <= odd_next;
            finish_reg  <= finish_next;
            hit_reg     <= hit_next;
        end
        x_reg  <= x_next;
        y_reg  <= y_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
    end

`ifndef SYNTHESIS
    a_stride_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(stride_reg)) else $error("stride not a power of two");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_busy) else $error("result overwritten");
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("request taken while busy");
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (state_reg == S_CLEAR || state_reg == S_ADD))
        else $error("grid write outside clear or update");
`endif

endmodule

// File: hw/rtl/diamond_square_heightmap.sv
// read request: registered grid read, then result register; reset request: 66049-cell clear, then 4 corners
// iterate request: for each generated point, 4 neighbor reads through the single
//   grid read port, then average and update; a full finish of the 257x257 grid is about
//   66045 points; one request is in work at a time
// after reset the grid memory is swept to zero, all 66049 cells, before the first request
// reset (aresetn, synchronous, active low) clears control, generator and stride
module diamond_square_heightmap import dsh_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [31:0]        s_seed,
    input  logic [8:0]         s_row,
    input  logic [8:0]         s_column,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_height,
    output logic               m_done_res
);

    // commands from the sequencer into the datapath, status back
    dsh_cmd_t    cmd;
    dsh_status_t status;

    // sequencer: clear sweep, corner seeding, square and diamond point walk, reads
    dsh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_row    (s_row),
        .s_column (s_column),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: grid memory, generator, neighbor sum, averaging, saturation, result register
    dsh_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_seed     (s_seed),
        .m_ready    (m_ready),
        .status     (status),
        .m_valid    (m_valid),
        .m_height   (m_height),
        .m_done_res (m_done_res)
    );

endmodule
